FILE: sv/min_count_subset_sum_dp_top_assert.svh
// Assertion macros used by the least-count subset-sum table RTL.
`ifndef MIN_COUNT_SUBSET_SUM_DP_TOP_ASSERT_SVH
`define MIN_COUNT_SUBSET_SUM_DP_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MCSSDP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define MCSSDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/mcssdp_pkg.sv
// Types and constants of the least-count subset-sum table.
package mcssdp_pkg;

  localparam int TABLE_DEPTH = 65536;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = IDX_W + 1;
  localparam int CFG_W       = 17;
  localparam int CMP_W       = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;
  localparam int SIZE_RESET  = (TABLE_DEPTH < 65536) ? TABLE_DEPTH : 65536;
  localparam int CNT_W       = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CNT_W-1:0] UNREACH = CNT_W'(254);

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Work codes handed from front to back.
  typedef enum logic [1:0] {
    OP_ADD,
    OP_READ,
    OP_MISS,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] weight;
    logic [IDX_W-1:0] addr;   // read index, or top index of an add sweep
  } qitem_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

FILE: sv/min_count_subset_sum_dp_top.sv
// Top level of the least-count subset-sum table.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    req_type, item_weight, query_index
//  out      source     out_valid / out_ready  min_count, reachable
//  cfg      sink       cfg_valid / cfg_ready  table_size
//
// Add: a descending sweep, one read-modify-write of the table RAM per cycle.
// Clear: one RAM write per cycle across every entry of the table.
// Read: through the registered RAM read port and S_READ; out-of-range reads skip the RAM.
// After reset a clearing pass over the whole table runs with in_ready low.
// A two-entry queue lets requests come in while the back end sweeps;
// a stalled result holds the back end only for the next read.
module min_count_subset_sum_dp_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] table_size,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [15:0] item_weight,
  input  logic [15:0] query_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  min_count,
  output logic        reachable
);
  import mcssdp_pkg::*;

  back_status_t status;
  logic         push_valid;
  logic         push_ready;
  qitem_t       push_item;
  logic         q_valid;
  logic         q_pop;
  qitem_t       q_item;

  mcssdp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .table_size  (table_size),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .item_weight (item_weight),
    .query_index (query_index),
    .status      (status),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  mcssdp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  mcssdp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .min_count (min_count),
    .reachable (reachable)
  );

endmodule

FILE: sv/mcssdp_ram.sv
// Generic RAM: one write port, two registered read ports.
module mcssdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: sv/mcssdp_front.sv
// Front end: size register, request decode and push into the work queue.
module mcssdp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [16:0]                 table_size,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  req_type,
  input  logic [15:0]                 item_weight,
  input  logic [15:0]                 query_index,
  input  mcssdp_pkg::back_status_t    status,
  output logic                        push_valid,
  input  logic                        push_ready,
  output mcssdp_pkg::qitem_t          push_item
);
  import mcssdp_pkg::*;

  logic [SIZE_W-1:0] active_size;
  logic [CMP_W-1:0]  cfg_ext;
  logic [CMP_W-1:0]  size_ext;
  logic [CMP_W-1:0]  w_ext;
  logic [CMP_W-1:0]  q_ext;
  logic              keep;

  assign cfg_ready = 1'b1;
  assign cfg_ext   = CMP_W'(table_size);

  // Saturate the written size into 2 .. TABLE_DEPTH.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= SIZE_W'(SIZE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_ext < CMP_W'(2)) begin
        active_size <= SIZE_W'(2);
      end else if (cfg_ext > CMP_W'(TABLE_DEPTH)) begin
        active_size <= SIZE_W'(TABLE_DEPTH);
      end else begin
        active_size <= SIZE_W'(cfg_ext);
      end
    end
  end

  assign size_ext = CMP_W'(active_size);
  assign w_ext    = CMP_W'(item_weight);
  assign q_ext    = CMP_W'(query_index);

  always_comb begin
    keep             = 1'b0;
    push_item.op     = OP_CLEAR;
    push_item.weight = IDX_W'(item_weight);
    push_item.addr   = IDX_W'(query_index);
    unique case (req_type)
      REQ_ADD: begin
        // zero weight or weight past the table changes nothing
        keep           = (item_weight != 16'd0) && (w_ext < size_ext);
        push_item.op   = OP_ADD;
        push_item.addr = IDX_W'(active_size - SIZE_W'(1));
      end
      REQ_READ: begin
        keep         = 1'b1;
        push_item.op = (q_ext < size_ext) ? OP_READ : OP_MISS;
      end
      REQ_CLEAR: begin
        keep         = 1'b1;
        push_item.op = OP_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready   = push_ready && !status.init_busy;
  assign push_valid = in_valid && in_ready && keep;

endmodule

FILE: sv/mcssdp_queue.sv
// Short work queue between front and back.
module mcssdp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  mcssdp_pkg::qitem_t push_item,
  output logic               pop_valid,
  input  logic               pop,
  output mcssdp_pkg::qitem_t pop_item
);
  import mcssdp_pkg::*;

  qitem_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

FILE: sv/mcssdp_back.sv
// Back end: table sweeps for add and clear, reads, and the result register.
module mcssdp_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  mcssdp_pkg::qitem_t       q_item,
  output mcssdp_pkg::back_status_t status,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               min_count,
  output logic                     reachable
);
  import mcssdp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ADD,
    S_DRAIN,
    S_CLEAR
  } state_t;

  state_t            state;
  logic              init_done;
  logic [IDX_W-1:0]  clr_cnt;
  logic [IDX_W-1:0]  issue_n;
  logic [IDX_W-1:0]  weight;
  logic              pend_valid;
  logic [IDX_W-1:0]  pend_addr;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [CNT_W-1:0]  wdata;
  logic [IDX_W-1:0]  raddr_a;
  logic [IDX_W-1:0]  raddr_b;
  logic [CNT_W-1:0]  rdata_a;
  logic [CNT_W-1:0]  rdata_b;
  logic [CNT_W-1:0]  inc;
  logic              needs_out;

  mcssdp_ram #(
    .WIDTH (CNT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign status.init_busy = !init_done;

  assign needs_out = (q_item.op == OP_READ) || (q_item.op == OP_MISS);
  assign q_pop     = (state == S_IDLE) && q_valid && (!needs_out || !out_valid);

  // Port a reads the target entry (or the queried one), port b the entry w below.
  assign raddr_a = (state == S_IDLE) ? q_item.addr : issue_n;
  assign raddr_b = issue_n - weight;

  assign inc = (rdata_b >= UNREACH) ? UNREACH : rdata_b + CNT_W'(1);

  always_comb begin
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = (clr_cnt == '0) ? '0 : UNREACH;
    end else begin
      we    = pend_valid;
      waddr = pend_addr;
      wdata = (inc < rdata_a) ? inc : rdata_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      init_done  <= 1'b0;
      clr_cnt    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      pend_valid <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            unique case (q_item.op)
              OP_READ: begin
                state <= S_READ;
              end
              OP_MISS: begin
                out_valid <= 1'b1;
                min_count <= UNREACH;
                reachable <= 1'b0;
              end
              OP_ADD: begin
                issue_n <= q_item.addr;
                weight  <= q_item.weight;
                state   <= S_ADD;
              end
              OP_CLEAR: begin
                clr_cnt <= '0;
                state   <= S_CLEAR;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_READ: begin
          out_valid <= 1'b1;
          min_count <= rdata_a;
          reachable <= (rdata_a < UNREACH);
          state     <= S_IDLE;
        end
        S_ADD: begin
          // descending sweep: entries below n are still pre-add values
          pend_valid <= 1'b1;
          pend_addr  <= issue_n;
          if (issue_n == weight) begin
            state <= S_DRAIN;
          end else begin
            issue_n <= issue_n - IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_IDLE;
        end
        S_CLEAR: begin
          if (clr_cnt == IDX_W'(TABLE_DEPTH - 1)) begin
            init_done <= 1'b1;
            state     <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + IDX_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "min_count_subset_sum_dp_top_assert.svh"

  `MCSSDP_ASSERT_IMPL(a_write_above_read, clk, rst, (state == S_ADD) && pend_valid, pend_addr == issue_n + IDX_W'(1))
  `MCSSDP_ASSERT_IMPL(a_sweep_above_weight, clk, rst, state == S_ADD, issue_n >= weight)
  `MCSSDP_ASSERT_IMPL(a_read_slot_free, clk, rst, state == S_READ, !out_valid && !we)
  `MCSSDP_ASSERT_IMPL(a_reach_matches, clk, rst, out_valid, reachable == (min_count < UNREACH))
  `MCSSDP_ASSERT_NEXT(a_drain_writes, clk, rst, state == S_DRAIN, state == S_IDLE)

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the least-count subset-sum table top level.
`timescale 1ns / 100ps

module testbench;
  import mcssdp_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;  // unused request code, ignored by the block
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 7;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  req;
    logic [15:0] w;
    logic [15:0] q;
    logic [16:0] size;
    logic        lit_on;
    logic [7:0]  lit_cnt;
    logic        lit_reach;
  } stim_row_t;

  typedef struct {
    logic [7:0] cnt;
    logic       reach;
  } read_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] table_size;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type;
  logic [15:0] item_weight;
  logic [15:0] query_index;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  min_count;
  logic        reachable;

  // Predicted table contents and active size register.
  logic [7:0]   tally [0:TABLE_DEPTH-1];
  logic [16:0]  size_reg;
  read_result_t pending_reads [$];
  stim_row_t    script [$];

  int errors = 0;
  bit tx_burst = 0;
  bit rx_burst = 0;
  bit hold_armed = 0;

  min_count_subset_sum_dp_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .table_size (table_size),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .item_weight(item_weight),
    .query_index(query_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .min_count  (min_count),
    .reachable  (reachable)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int span();
    int s;
    s = int'(size_reg);
    if (s < 2) s = 2;
    if (s > TABLE_DEPTH) s = TABLE_DEPTH;
    return s;
  endfunction

  function automatic int idle_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 3);
  endfunction

  task automatic tally_clear();
    for (int n = 0; n < TABLE_DEPTH; n++) tally[n] = UNREACH;
    tally[0] = '0;
  endtask

  // Downward sweep so each item is counted at most once per sum.
  task automatic tally_add(input int w);
    int s;
    logic [8:0] c;
    s = span();
    if (w == 0 || w >= s) return;
    for (int n = s - 1; n >= w; n--) begin
      c = {1'b0, tally[n-w]} + 9'd1;
      if (c > {1'b0, UNREACH}) c = {1'b0, UNREACH};
      if (c[7:0] < tally[n]) tally[n] = c[7:0];
    end
  endtask

  task automatic apply_request(input logic [1:0] req, input logic [15:0] w,
                               input logic [15:0] q);
    read_result_t r;
    case (req)
      REQ_ADD: tally_add(int'(w));
      REQ_CLEAR: tally_clear();
      REQ_READ: begin
        r.cnt = (int'(q) < span()) ? tally[q] : UNREACH;
        r.reach = (r.cnt < UNREACH);
        pending_reads.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic offer(input logic [1:0] req, input logic [15:0] w, input logic [15:0] q,
                       input int gap, input logic lit_on, input logic [7:0] lit_cnt,
                       input logic lit_reach);
    read_result_t r;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    item_weight <= w;
    query_index <= q;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (lit_on) begin
      r.cnt = lit_cnt;
      r.reach = lit_reach;
      pending_reads.push_back(r);
    end else begin
      apply_request(req, w, q);
    end
  endtask

  // Always waits for a clock edge, then for all reads to return.
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reads.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_size(input logic [16:0] v);
    cfg_valid  <= 1'b1;
    table_size <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    size_reg = v;
  endtask

  // Result side: random stalls, one long hold-off when armed.
  initial begin
    read_result_t want;
    int stall;
    int seen;
    seen = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_armed) begin
        hold_armed = 0;
        stall = HOLD_CYCLES;
      end else begin
        stall = idle_gap(rx_burst);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      seen++;
      if (seen % 16 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (pending_reads.size() == 0) begin
        $display("%0t unexpected result: min_count %0d reachable %0d",
                 $time, min_count, reachable);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        if (min_count !== want.cnt) begin
          $display("%0t min_count mismatch: expected %0d, actual %0d",
                   $time, want.cnt, min_count);
          errors++;
        end
        if (reachable !== want.reach) begin
          $display("%0t reachable mismatch: expected %0d, actual %0d",
                   $time, want.reach, reachable);
          errors++;
        end
      end
    end
  end

  initial begin
    int s;
    int r;
    int counted;
    int clears_left;
    logic [1:0]  req;
    logic [15:0] w;
    logic [15:0] q;
    logic [16:0] sz;

    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    table_size  <= '0;
    in_valid    <= 1'b0;
    req_type    <= REQ_ADD;
    item_weight <= '0;
    query_index <= '0;

    // Fresh table at full size, then extremes of weight, index and size.
    script.push_back('{ROW_REQ, REQ_READ, 16'd0, 16'd0, 17'd0, 1'b1, 8'd0, 1'b1});
    script.push_back('{ROW_REQ, REQ_READ, 16'd0, 16'd65535, 17'd0, 1'b1, UNREACH, 1'b0});
    script.push_back('{ROW_REQ, REQ_READ, 16'd0, 16'd1, 17'd0, 1'b1, UNREACH, 1'b0});
    script.push_back('{ROW_REQ, REQ_ADD, 16'd0, 16'd0, 17'd0, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_REQ, REQ_NONE, 16'd65535, 16'd65535, 17'd0, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_REQ, REQ_ADD, 16'd65535, 16'd0, 17'd0, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_REQ, REQ_READ, 16'd0, 16'd65535, 17'd0, 1'b1, 8'd1, 1'b1});
    script.push_back('{ROW_REQ, REQ_ADD, 16'd1, 16'd0, 17'd0, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_REQ, REQ_ADD, 16'd1, 16'd0, 17'd0, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_REQ, REQ_READ, 16'd0, 16'd2, 17'd0, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_REQ, REQ_READ, 16'd0, 16'd1, 17'd0, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_CFG, REQ_ADD, 16'd0, 16'd0, 17'd0, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_REQ, REQ_ADD, 16'd1, 16'd0, 17'd0, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_REQ, REQ_ADD, 16'd2, 16'd0, 17'd0, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_REQ, REQ_READ, 16'd0, 16'd1, 17'd0, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_REQ, REQ_READ, 16'd0, 16'd2, 17'd0, 1'b1, UNREACH, 1'b0});
    script.push_back('{ROW_REQ, REQ_READ, 16'd0, 16'd65535, 17'd0, 1'b1, UNREACH, 1'b0});
    script.push_back('{ROW_CFG, REQ_ADD, 16'd0, 16'd0, 17'd131071, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_REQ, REQ_READ, 16'd0, 16'd65535, 17'd0, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_REQ, REQ_READ, 16'd0, 16'd2, 17'd0, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_REQ, REQ_CLEAR, 16'd0, 16'd0, 17'd0, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_REQ, REQ_READ, 16'd0, 16'd0, 17'd0, 1'b1, 8'd0, 1'b1});
    script.push_back('{ROW_REQ, REQ_READ, 16'd0, 16'd65535, 17'd0, 1'b1, UNREACH, 1'b0});
    script.push_back('{ROW_CFG, REQ_ADD, 16'd0, 16'd0, 17'd65536, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_REQ, REQ_ADD, 16'd32768, 16'd0, 17'd0, 1'b0, 8'd0, 1'b0});
    script.push_back('{ROW_REQ, REQ_READ, 16'd0, 16'd32768, 17'd0, 1'b0, 8'd0, 1'b0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    size_reg = 17'(SIZE_RESET);
    tally_clear();

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        settle(8);
        write_size(script[i].size);
      end else begin
        offer(script[i].req, script[i].w, script[i].q, idle_gap(tx_burst),
              script[i].lit_on, script[i].lit_cnt, script[i].lit_reach);
      end
    end

    // Random phases, each at its own size; large sizes get cheap sweeps only.
    clears_left = 2;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: sz = 17'd2;
        1: sz = 17'd131071;
        2: sz = 17'($urandom_range(3, 64));
        3: sz = 17'd0;
        4: sz = 17'($urandom_range(65, 700));
        5: sz = 17'($urandom_range(2, 40));
        6: sz = 17'(65536 + $urandom_range(0, 65535));
        7: sz = 17'($urandom_range(3, 300));
        default: sz = 17'($urandom_range(2, 70000));
      endcase
      settle(8);
      write_size(sz);
      s = span();
      tx_burst = ($urandom_range(0, 3) == 0);

      if (p == 2) begin
        // Back-to-back reads against a stalled result side.
        hold_armed = 1;
        repeat (PHASE_ITEMS) begin
          offer(REQ_READ, 16'($urandom), 16'($urandom_range(0, s - 1)), 0,
                1'b0, 8'd0, 1'b0);
        end
      end

      counted = 0;
      while (counted < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        w = 16'($urandom);
        q = 16'($urandom);
        if (r < 5) begin
          req = REQ_NONE;
        end else if (r < 8 && clears_left > 0) begin
          req = REQ_CLEAR;
          clears_left--;
        end else if (r < 55) begin
          req = REQ_ADD;
          r = $urandom_range(0, 99);
          if (r < 5) w = 16'd0;
          else if (r < 85 && s <= 1024) w = 16'($urandom_range(1, s - 1));
          else if (s > 1024) w = 16'($urandom_range(s - 200, s - 1));
        end else begin
          req = REQ_READ;
          if ($urandom_range(0, 99) < 80) q = 16'($urandom_range(0, s - 1));
        end
        if (req != REQ_NONE) counted++;
        offer(req, w, q, idle_gap(tx_burst), 1'b0, 8'd0, 1'b0);
        if ($urandom_range(0, 24) == 0) settle(0);
      end
      // Trailing read orders behind all sweeps of the phase.
      offer(REQ_READ, 16'($urandom), 16'($urandom_range(0, s - 1)), idle_gap(tx_burst),
            1'b0, 8'd0, 1'b0);
    end

    settle(16);
    if (pending_reads.size() != 0) errors++;
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
